@@ rtl/core/fire_effect_cell_updater_macros.svh @@
// Assertion macros shared by the fire effect cell updater RTL.
`ifndef FIRE_EFFECT_CELL_UPDATER_MACROS_SVH
`define FIRE_EFFECT_CELL_UPDATER_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define FEU_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define FEU_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/core/feu_pkg.sv @@
// Package: grid geometry, opcodes, shared types and the fire palette.
`default_nettype none

package feu_pkg;

    localparam int GRID_WIDTH  = 200;
    localparam int GRID_HEIGHT = 96;
    localparam int GRID_CELLS  = GRID_WIDTH * GRID_HEIGHT;

    localparam int ADDR_W = $clog2(GRID_CELLS);
    localparam int COL_W  = $clog2(GRID_WIDTH);
    localparam int ROW_W  = $clog2(GRID_HEIGHT);
    localparam int HEAT_W = 6;

    localparam logic [HEAT_W-1:0] MAX_HEAT = 6'd35;

    localparam logic OP_STEP = 1'b0;
    localparam logic OP_READ = 1'b1;

    // 5*f compared against 0.4 and 0.8 of 5*65536
    localparam logic [18:0] LEFT_LIMIT  = 19'd131072;
    localparam logic [18:0] RIGHT_LIMIT = 19'd262144;

    typedef logic [ADDR_W-1:0] t_addr;
    typedef logic [HEAT_W-1:0] t_heat;

    typedef struct packed {
        t_addr addr;   // linear address of the cursor cell
        logic  wrap;   // cursor sits on the last interior cell of the frame
    } t_cursor;

    typedef struct packed {
        t_heat value;  // decayed intensity
        t_addr dest;   // cell that receives it
    } t_step_res;

    function automatic logic [23:0] palette(input t_heat heat);
        logic [23:0] rgb;
        case (heat)
            6'd0:    rgb = {8'd0,   8'd0,   8'd0};
            6'd1:    rgb = {8'd31,  8'd7,   8'd7};
            6'd2:    rgb = {8'd47,  8'd15,  8'd7};
            6'd3:    rgb = {8'd71,  8'd15,  8'd7};
            6'd4:    rgb = {8'd87,  8'd23,  8'd7};
            6'd5:    rgb = {8'd103, 8'd31,  8'd7};
            6'd6:    rgb = {8'd119, 8'd31,  8'd7};
            6'd7:    rgb = {8'd143, 8'd39,  8'd7};
            6'd8:    rgb = {8'd159, 8'd47,  8'd7};
            6'd9:    rgb = {8'd175, 8'd63,  8'd7};
            6'd10:   rgb = {8'd191, 8'd71,  8'd7};
            6'd11:   rgb = {8'd199, 8'd71,  8'd7};
            6'd12:   rgb = {8'd223, 8'd79,  8'd7};
            6'd13:   rgb = {8'd223, 8'd87,  8'd7};
            6'd14:   rgb = {8'd223, 8'd87,  8'd7};
            6'd15:   rgb = {8'd215, 8'd95,  8'd7};
            6'd16:   rgb = {8'd215, 8'd103, 8'd15};
            6'd17:   rgb = {8'd207, 8'd111, 8'd15};
            6'd18:   rgb = {8'd207, 8'd119, 8'd15};
            6'd19:   rgb = {8'd207, 8'd127, 8'd15};
            6'd20:   rgb = {8'd207, 8'd137, 8'd23};
            6'd21:   rgb = {8'd199, 8'd135, 8'd23};
            6'd22:   rgb = {8'd199, 8'd143, 8'd23};
            6'd23:   rgb = {8'd199, 8'd151, 8'd31};
            6'd24:   rgb = {8'd191, 8'd159, 8'd31};
            6'd25:   rgb = {8'd191, 8'd159, 8'd31};
            6'd26:   rgb = {8'd191, 8'd167, 8'd39};
            6'd27:   rgb = {8'd191, 8'd167, 8'd39};
            6'd28:   rgb = {8'd191, 8'd175, 8'd47};
            6'd29:   rgb = {8'd183, 8'd175, 8'd47};
            6'd30:   rgb = {8'd183, 8'd183, 8'd47};
            6'd31:   rgb = {8'd183, 8'd183, 8'd55};
            6'd32:   rgb = {8'd207, 8'd207, 8'd111};
            6'd33:   rgb = {8'd223, 8'd223, 8'd159};
            6'd34:   rgb = {8'd239, 8'd239, 8'd199};
            default: rgb = {8'd255, 8'd255, 8'd255};  // 35 and above saturate
        endcase
        return rgb;
    endfunction

endpackage

`default_nettype wire

@@ rtl/core/feu_if.sv @@
// Interfaces: command and result channels with valid/ready handshake.
`default_nettype none

interface feu_in_if;
    logic       valid;
    logic       ready;
    logic       opcode;
    logic [15:0] random_fraction;
    logic [7:0] read_column;
    logic [6:0] read_row;

    modport source (output valid, opcode, random_fraction, read_column, read_row,
                    input ready);
    modport sink   (input valid, opcode, random_fraction, read_column, read_row,
                    output ready);
endinterface

interface feu_out_if;
    logic       valid;
    logic       ready;
    logic [5:0] intensity;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       frame_done;

    modport source (output valid, intensity, red, green, blue, frame_done,
                    input ready);
    modport sink   (input valid, intensity, red, green, blue, frame_done,
                    output ready);
endinterface

`default_nettype wire

@@ rtl/core/feu_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module feu_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]         i_wr_data,
    input  wire logic                     i_rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule

`default_nettype wire

@@ rtl/core/feu_cursor.sv @@
// Interior cursor: walks rows inside columns, keeps its linear address.
`default_nettype none

module feu_cursor
    import feu_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_advance,
    output t_cursor      o_cursor
);

    logic [COL_W-1:0] r_col, n_col;
    logic [ROW_W-1:0] r_row, n_row;
    t_addr            r_addr, n_addr;
    logic             w_last_row;
    logic             w_last_col;

    assign w_last_row = (r_row == ROW_W'(GRID_HEIGHT - 2));
    assign w_last_col = (r_col == COL_W'(GRID_WIDTH - 2));

    always_comb begin
        n_col  = r_col;
        n_row  = r_row;
        n_addr = r_addr;
        if (i_advance) begin
            if (!w_last_row) begin
                n_row  = r_row + 1'b1;
                n_addr = r_addr + 1'b1;
            end else if (!w_last_col) begin
                // skip the bottom row and the top row of the next column
                n_row  = ROW_W'(1);
                n_col  = r_col + 1'b1;
                n_addr = r_addr + ADDR_W'(3);
            end else begin
                n_row  = ROW_W'(1);
                n_col  = COL_W'(1);
                n_addr = ADDR_W'(GRID_HEIGHT + 1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col  <= COL_W'(1);
            r_row  <= ROW_W'(1);
            r_addr <= ADDR_W'(GRID_HEIGHT + 1);
        end else begin
            r_col  <= n_col;
            r_row  <= n_row;
            r_addr <= n_addr;
        end
    end

    assign o_cursor.addr = r_addr;
    assign o_cursor.wrap = w_last_row && w_last_col;

endmodule

`default_nettype wire

@@ rtl/core/feu_step_calc.sv @@
// Step arithmetic: decay the cell below and pick the neighbor to write.
`default_nettype none

module feu_step_calc
    import feu_pkg::*;
(
    input  wire t_heat        i_below,
    input  wire logic [15:0]  i_frac,
    input  wire t_addr        i_base,
    output t_step_res         o_res
);

    logic [17:0] w_frac3;
    logic [18:0] w_frac5;
    logic [1:0]  w_decay;

    assign w_frac3 = 18'(i_frac) * 18'd3;
    assign w_frac5 = 19'(i_frac) * 19'd5;
    assign w_decay = w_frac3[17:16];

    always_comb begin
        o_res.value = (i_below > HEAT_W'(w_decay)) ? (i_below - HEAT_W'(w_decay))
                                                    : '0;
        if (w_frac5 < LEFT_LIMIT) begin
            o_res.dest = i_base - ADDR_W'(GRID_HEIGHT);
        end else if (w_frac5 <= RIGHT_LIMIT) begin
            o_res.dest = i_base + ADDR_W'(GRID_HEIGHT);
        end else begin
            o_res.dest = i_base - 1'b1;
        end
    end

endmodule

`default_nettype wire

@@ rtl/core/fire_effect_cell_updater.sv @@
// Top level: fire effect grid with step and palette-read operations.
//
// Usage:
//   i_in carries one command word: opcode 0 runs one propagation step at the
//   internal cursor (random_fraction picks decay and direction), opcode 1
//   reads the cell at read_column/read_row. o_out returns one result word per
//   command: the written or read intensity, the palette color for reads, and
//   frame_done on the step that finishes the last interior cell of a frame.
//   Commands do not overlap: a new command is taken only after the previous
//   one has executed; the grid memory has one port pair, each command reads
//   it when accepted and a step writes it back when it executes, so the
//   following read always sees the finished write.
//   Reset: the cursor returns to column 1, row 1 and a clearing pass writes
//   all 19200 grid cells (35 on the bottom row, 0 elsewhere), one per cycle;
//   i_in.ready stays low until the pass is done.
//   Stall: one result word waits in the output register while the next
//   command is taken and its memory read is done; that command then holds
//   until the output register frees up.
`default_nettype none

`include "fire_effect_cell_updater_macros.svh"

module fire_effect_cell_updater
    import feu_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    feu_in_if.sink    i_in,
    feu_out_if.source o_out
);

    localparam logic [1:0] S_CLEAR = 2'd0;
    localparam logic [1:0] S_IDLE  = 2'd1;
    localparam logic [1:0] S_EXEC  = 2'd2;

    logic [1:0]       r_state, n_state;
    t_addr            r_clr_addr;
    logic [ROW_W-1:0] r_clr_row;
    logic             w_clr_last;

    // command held between accept and execute
    logic             r_op;
    logic [15:0]      r_frac;
    logic             r_oob;
    logic             r_done;
    t_addr            r_base;

    logic             r_out_valid;
    t_heat            r_out_heat;
    logic [23:0]      r_out_rgb;
    logic             r_out_done;

    logic             w_accept;
    logic             w_out_free;
    logic             w_exec_fire;
    t_cursor          w_cursor;
    t_step_res        w_step;
    t_heat            w_rd_data;
    t_heat            w_read_heat;
    t_addr            w_read_addr;

    logic             w_we;
    t_addr            w_wr_addr;
    t_heat            w_wr_data;
    t_addr            w_rd_addr;

    assign i_in.ready  = (r_state == S_IDLE);
    assign w_accept    = i_in.valid && i_in.ready;
    assign w_out_free  = !r_out_valid || o_out.ready;
    assign w_exec_fire = (r_state == S_EXEC) && w_out_free;
    assign w_clr_last  = (r_clr_addr == ADDR_W'(GRID_CELLS - 1));

    assign w_read_addr = ADDR_W'(i_in.read_column) * ADDR_W'(GRID_HEIGHT)
                       + ADDR_W'(i_in.read_row);
    assign w_rd_addr   = (i_in.opcode == OP_READ) ? w_read_addr
                                                  : (w_cursor.addr + 1'b1);

    feu_cursor u_cursor (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_advance (w_accept && (i_in.opcode == OP_STEP)),
        .o_cursor  (w_cursor)
    );

    feu_ram #(
        .WIDTH (HEAT_W),
        .DEPTH (GRID_CELLS)
    ) u_grid (
        .i_clk     (i_clk),
        .i_we      (w_we),
        .i_wr_addr (w_wr_addr),
        .i_wr_data (w_wr_data),
        .i_rd_en   (w_accept),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_rd_data)
    );

    feu_step_calc u_calc (
        .i_below (w_rd_data),
        .i_frac  (r_frac),
        .i_base  (r_base),
        .o_res   (w_step)
    );

    // write port: clearing sweep, or the step write-back when the result enters the output register
    always_comb begin
        w_we      = 1'b0;
        w_wr_addr = r_clr_addr;
        w_wr_data = (r_clr_row == ROW_W'(GRID_HEIGHT - 1)) ? MAX_HEAT : '0;
        if (r_state == S_CLEAR) begin
            w_we = 1'b1;
        end else if (w_exec_fire && (r_op == OP_STEP)) begin
            w_we      = 1'b1;
            w_wr_addr = w_step.dest;
            w_wr_data = w_step.value;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR: begin
                if (w_clr_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (w_accept) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr_addr  <= '0;
            r_clr_row   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_CLEAR) begin
                r_clr_addr <= r_clr_addr + 1'b1;
                r_clr_row  <= (r_clr_row == ROW_W'(GRID_HEIGHT - 1)) ? '0
                                                                      : r_clr_row + 1'b1;
            end
            if (w_exec_fire) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // capture the command at accept
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_op   <= i_in.opcode;
            r_frac <= i_in.random_fraction;
            r_oob  <= (32'(i_in.read_column) >= GRID_WIDTH)
                   || (32'(i_in.read_row) >= GRID_HEIGHT);
            r_done <= (i_in.opcode == OP_STEP) && w_cursor.wrap;
            r_base <= w_cursor.addr;
        end
    end

    // cells outside the grid read as zero heat
    assign w_read_heat = r_oob ? '0 : w_rd_data;

    always_ff @(posedge i_clk) begin
        if (w_exec_fire) begin
            if (r_op == OP_READ) begin
                r_out_heat <= (w_read_heat > MAX_HEAT) ? MAX_HEAT : w_read_heat;
                r_out_rgb  <= palette(w_read_heat);
                r_out_done <= 1'b0;
            end else begin
                r_out_heat <= w_step.value;
                r_out_rgb  <= '0;
                r_out_done <= r_done;
            end
        end
    end

    assign o_out.valid      = r_out_valid;
    assign o_out.intensity  = r_out_heat;
    assign o_out.red        = r_out_rgb[23:16];
    assign o_out.green      = r_out_rgb[15:8];
    assign o_out.blue       = r_out_rgb[7:0];
    assign o_out.frame_done = r_out_done;

    `FEU_ASSERT_NEXT(a_accept_to_exec, i_clk, i_rst_n, w_accept, r_state == S_EXEC,
        "accepted command did not move to execute")
    `FEU_ASSERT_NOW(a_result_from_exec, i_clk, i_rst_n, $rose(r_out_valid),
        $past(r_state) == S_EXEC, "result word appeared without an execute cycle")
    `FEU_ASSERT_NOW(a_write_in_grid, i_clk, i_rst_n, w_we,
        32'(w_wr_addr) < GRID_CELLS, "grid write address beyond the grid")
    `FEU_ASSERT_NOW(a_step_write_interior, i_clk, i_rst_n,
        w_we && (r_state == S_EXEC),
        (32'(r_base) > GRID_HEIGHT) && (32'(r_base) < GRID_CELLS - GRID_HEIGHT),
        "step cursor outside the grid interior")

endmodule

`default_nettype wire
